// File: design/edma_pkg.sv
// ----------------------------------------------------------------------------
// edma_pkg: shared types and constants for the echo distance averager
// Field widths, preset values and the pulse-width scaling constant.
// ----------------------------------------------------------------------------
`default_nettype none

package edma_pkg;

   // field widths
   localparam int unsigned WIDTH_W = 15;
   localparam int unsigned DIST_W  = 10;

   typedef logic [WIDTH_W-1:0] width_type;
   typedef logic [DIST_W-1:0]  dist_type;

   // defaults and limits
   localparam int unsigned WINDOW_DEFAULT = 8;
   localparam int unsigned SAMPLE_MAX     = 1023;

   localparam dist_type PRESET_SAMPLE  = 10'd150;
   localparam dist_type LIMIT_OUTPUT   = 10'd700;
   localparam dist_type TIMEOUT_STEP   = 10'd10;
   localparam dist_type MAX_DIST_RESET = 10'd400;

   // floor(w * 17 / 1000) == (w * SCALE_MULT) >> SCALE_SHIFT for every 15-bit w
   localparam int unsigned SCALE_SHIFT  = 30;
   localparam int unsigned SCALE_MULT_W = 25;
   localparam int unsigned SCALE_PROD_W = WIDTH_W + SCALE_MULT_W;
   localparam logic [SCALE_MULT_W-1:0] SCALE_MULT = 25'd18253614;

   // converted word handed from the scaler to the averaging loop
   typedef struct packed {
      logic     valid;
      dist_type raw;
   } raw_word_type;

endpackage

`default_nettype wire

// File: design/edma_cell.sv
// ----------------------------------------------------------------------------
// edma_cell: one sample cell of the averaging window
// Holds one distance sample and takes its neighbour's sample on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module edma_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               shift,
   input  wire edma_pkg::dist_type d,
   output edma_pkg::dist_type      q
);
   import edma_pkg::*;

   dist_type sample_ff;

   // window preset on reset, shift on each new word
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= PRESET_SAMPLE;
      end else if (shift) begin
         sample_ff <= d;
      end
   end

   assign q = sample_ff;

endmodule

`default_nettype wire

// File: design/edma_scale.sv
// ----------------------------------------------------------------------------
// edma_scale: pulse width to raw centimetres
// Two-stage pipeline: input register, then reciprocal multiply and register.
// ----------------------------------------------------------------------------
`default_nettype none

module edma_scale (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire edma_pkg::width_type in_width,
   output edma_pkg::raw_word_type   out_word,
   input  wire logic                out_ready
);
   import edma_pkg::*;

   logic                    v1_ff;
   width_type               width_ff;
   logic                    v2_ff;
   dist_type                raw_ff;
   logic                    ready1;
   logic                    ready2;
   logic [SCALE_PROD_W-1:0] prod;
   dist_type                raw_in;

   // stage ready: free when empty or when its word moves on
   assign ready2   = !v2_ff || out_ready;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   // width * 17 / 1000 as one multiply by a scaled reciprocal
   assign prod   = SCALE_PROD_W'(width_ff) * SCALE_PROD_W'(SCALE_MULT);
   assign raw_in = prod[SCALE_SHIFT +: DIST_W];

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= in_valid;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (ready1 && in_valid) begin
         width_ff <= in_width;
      end
      if (ready2 && v1_ff) begin
         raw_ff <= raw_in;
      end
   end

   assign out_word.valid = v2_ff;
   assign out_word.raw   = raw_ff;

endmodule

`default_nettype wire

// File: design/echo_distance_moving_average.sv
// ----------------------------------------------------------------------------
// echo_distance_moving_average: filtered ultrasonic range
// Converts echo pulse widths to centimetres and averages them over a window.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one word per echo, pulse width in microseconds (0 = no echo).
//   rsp_*  : one word per echo, filtered distance in centimetres.
//   csr_*  : write of max_distance; csr_ready is always high. Write it only
//            while no word is in flight.
// A req word reaches rsp_tvalid through three registers: the input register
// (loaded on the edge that takes the req word), the multiply register, then
// the averaging step into the output register. Throughput is one word per
// cycle while rsp_tready stays high; the averaging step (one add/subtract
// through the running total, the mean and the limit compare) closes its
// loop combinationally, fed back through the output register.
// The window is a row of WINDOW cells shifting one place per word; the
// oldest cell leaves the running total.
// Reset: max_distance 400, every cell 150, total 150 * WINDOW, last output 0.
// Stall: a held rsp word stays put; the two stages ahead of it keep taking
// words until they are full, and req_tready then drops.
// ----------------------------------------------------------------------------
`default_nettype none

module echo_distance_moving_average #(
   parameter int unsigned WINDOW = edma_pkg::WINDOW_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request words
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [15:0]        req_tdata,   // [14:0] echo_width_us, [15] zero
   // response words
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [15:0]             rsp_tdata,   // [9:0] distance_cm, [15:10] zero
   // register write
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire edma_pkg::dist_type csr_data     // max_distance
);
   import edma_pkg::*;

   localparam int unsigned LOG2W   = $clog2(WINDOW);
   localparam int unsigned TOTAL_W = $clog2(WINDOW * SAMPLE_MAX + 1);
   localparam logic [TOTAL_W-1:0] PRESET_TOTAL = TOTAL_W'(PRESET_SAMPLE * WINDOW);
   localparam bit IS_POW2 = (WINDOW & (WINDOW - 1)) == 0;

   dist_type           max_dist_ff;
   raw_word_type       raw_word;
   logic               ready3;
   logic               fire3;
   logic               rsp_valid_ff;
   dist_type           dist_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] total_in;
   logic [DIST_W:0]    step_sum;
   dist_type           timeout_sample;
   dist_type           sample;
   dist_type           mean;
   dist_type           dist_in;
   dist_type           cell_q [WINDOW];
   dist_type           oldest;

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff <= MAX_DIST_RESET;
      end else if (csr_valid) begin
         max_dist_ff <= csr_data;
      end
   end

   // width scaling pipeline
   edma_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_width  (req_tdata[WIDTH_W-1:0]),
      .out_word  (raw_word),
      .out_ready (ready3)
   );

   // averaging step advances when the output register is free
   assign ready3 = !rsp_valid_ff || rsp_tready;
   assign fire3  = raw_word.valid && ready3;

   // window cells: cell 0 takes the new sample, the last one is the oldest
   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      if (i == 0) begin : g_head
         edma_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (fire3),
            .d     (sample),
            .q     (cell_q[i])
         );
      end else begin : g_body
         edma_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (fire3),
            .d     (cell_q[i-1]),
            .q     (cell_q[i])
         );
      end
   end

   assign oldest = cell_q[WINDOW-1];

   // sample: clamp, or previous output plus step on a timeout (saturating)
   assign step_sum       = {1'b0, dist_ff} + {1'b0, TIMEOUT_STEP};
   assign timeout_sample = step_sum[DIST_W] ? dist_type'(SAMPLE_MAX) : step_sum[DIST_W-1:0];

   always_comb begin
      if (raw_word.raw > max_dist_ff) begin
         sample = max_dist_ff;
      end else if (raw_word.raw == '0) begin
         sample = timeout_sample;
      end else begin
         sample = raw_word.raw;
      end
   end

   // running total
   assign total_in = total_ff - TOTAL_W'(oldest) + TOTAL_W'(sample);

   // mean: shift for a power-of-two window, reciprocal multiply otherwise
   if (IS_POW2) begin : g_mean_shift
      assign mean = total_in[LOG2W +: DIST_W];
   end else begin : g_mean_mul
      localparam int unsigned RECIP_SH = TOTAL_W + LOG2W;
      localparam int unsigned RECIP_W  = TOTAL_W + 1;
      localparam int unsigned PROD_W   = TOTAL_W + RECIP_W;
      localparam longint unsigned RECIP =
         ((64'd1 << RECIP_SH) + WINDOW - 1) / WINDOW;
      logic [PROD_W-1:0] prod;
      assign prod = PROD_W'(total_in) * PROD_W'(RECIP_W'(RECIP));
      assign mean = prod[RECIP_SH +: DIST_W];
   end

   // limit handling
   always_comb begin
      if (mean >= max_dist_ff) begin
         dist_in = LIMIT_OUTPUT;
      end else if (mean == '0) begin
         dist_in = sample;
      end else begin
         dist_in = mean;
      end
   end

   // loop state and output register; dist_ff doubles as the last output
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         total_ff     <= PRESET_TOTAL;
         dist_ff      <= '0;
      end else begin
         if (ready3) begin
            rsp_valid_ff <= raw_word.valid;
         end
         if (fire3) begin
            total_ff <= total_in;
            dist_ff  <= dist_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(16 - DIST_W)'(0), dist_ff};

   // checks
   a_reset_state: assert property (@(posedge clock)
      $fell(reset) |-> total_ff == PRESET_TOTAL && dist_ff == '0)
      else $error("window total or last output not preset after reset");

   a_total_covers_oldest: assert property (@(posedge clock) disable iff (reset)
      total_ff >= TOTAL_W'(oldest))
      else $error("running total below a stored sample");

   a_new_rsp_from_scaler: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !$past(rsp_tvalid) |-> $past(raw_word.valid))
      else $error("response word without a converted word behind it");

   a_rsp_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while the receiver held off");

endmodule

`default_nettype wire
